[design/sspq_pkg.sv]
package sspq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_IN_W = 8;
  localparam int OCC_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_POPPED    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_DROP_FULL = 2'd3
  } status_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_cmd_t;

endpackage

[design/sspq_if.sv]
interface sspq_in_if;
  import sspq_pkg::*;
  logic                        valid;
  logic                        ready;
  opcode_t                     opcode;
  logic signed [VALUE_W-1:0]   value;
  logic        [PRIO_IN_W-1:0] prio;

  modport source(output valid, opcode, value, prio, input ready);
  modport sink(input valid, opcode, value, prio, output ready);
endinterface

interface sspq_out_if;
  import sspq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] popped_value;
  status_t                   status;
  logic        [OCC_W-1:0]   occupancy;

  modport source(output valid, popped_value, status, occupancy, input ready);
  modport sink(input valid, popped_value, status, occupancy, output ready);
endinterface

[design/sspq_cell.sv]
module sspq_cell #(
  parameter int PRIO_BITS = 8
) (
  input  logic                            clk,
  input  sspq_pkg::cell_cmd_t             cmd,
  input  logic                            occupied,
  input  logic [sspq_pkg::VALUE_W-1:0]    new_val,
  input  logic [PRIO_BITS-1:0]            new_prio,
  input  logic                            left_stay,
  input  logic [sspq_pkg::VALUE_W-1:0]    left_val,
  input  logic [PRIO_BITS-1:0]            left_prio,
  input  logic [sspq_pkg::VALUE_W-1:0]    right_val,
  input  logic [PRIO_BITS-1:0]            right_prio,
  output logic [sspq_pkg::VALUE_W-1:0]    val,
  output logic [PRIO_BITS-1:0]            prio,
  output logic                            stay
);
  import sspq_pkg::*;

  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;

  // equal priority stays ahead of the newcomer
  assign stay = occupied && (prio_r <= new_prio);

  always_comb begin
    val_nxt  = val_r;
    prio_nxt = prio_r;
    if (cmd.ins) begin
      if (!stay) begin
        if (left_stay) begin
          val_nxt  = new_val;
          prio_nxt = new_prio;
        end else begin
          val_nxt  = left_val;
          prio_nxt = left_prio;
        end
      end
    end else if (cmd.pop) begin
      val_nxt  = right_val;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    prio_r <= prio_nxt;
  end

  assign val  = val_r;
  assign prio = prio_r;

endmodule

[design/stable_sorted_priority_queue.sv]
// Sorted priority queue, lower priority number served first, ties in arrival order.
// in_ch carries one word per operation: opcode insert (value, prio) or pop.
// out_ch returns exactly one word per accepted input: popped value (zero unless
// a pop succeeded), status (inserted, popped, pop on empty, insert dropped
// because full) and the occupancy after the operation.
// Storage is a row of QUEUE_DEPTH cells; every cell compares its priority with
// the incoming one in parallel and shifts toward its neighbor in the same cycle,
// so each operation updates all cells together.
// The result word is registered and shows in the cycle after acceptance.
// Throughput: one word per cycle while out_ch is ready.
// in_ch.ready is high whenever the result register is empty or being taken;
// when the receiver stalls the result holds and in_ch stalls with it.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result;
// there is no clearing pass, the queue is usable the cycle after reset.
module stable_sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PRIO_BITS   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  sspq_in_if.sink    in_ch,
  sspq_out_if.source out_ch
);
  import sspq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] popped_r, popped_nxt;
  status_t                   status_r, status_nxt;
  logic [OCC_W-1:0]          occ_r;

  logic                      accept, full, empty;
  cell_cmd_t                 cmd;
  logic [PRIO_BITS-1:0]      new_prio;

  logic [VALUE_W-1:0]   cell_val  [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [QUEUE_DEPTH];
  logic                 cell_stay [QUEUE_DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty       = (count_r == '0);
  assign new_prio    = PRIO_BITS'(in_ch.prio);

  assign cmd.ins = accept && (in_ch.opcode == OP_INSERT) && !full;
  assign cmd.pop = accept && (in_ch.opcode == OP_POP) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 l_stay;
    logic [VALUE_W-1:0]   l_val, r_val;
    logic [PRIO_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      // the head takes the newcomer whenever it does not stay itself
      assign l_stay = 1'b1;
      assign l_val  = in_ch.value;
      assign l_prio = new_prio;
    end else begin : g_mid
      assign l_stay = cell_stay[i-1];
      assign l_val  = cell_val[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_val  = cell_val[i];
      assign r_prio = cell_prio[i];
    end else begin : g_body
      assign r_val  = cell_val[i+1];
      assign r_prio = cell_prio[i+1];
    end

    sspq_cell #(.PRIO_BITS(PRIO_BITS)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (CNT_W'(i) < count_r),
      .new_val   (in_ch.value),
      .new_prio  (new_prio),
      .left_stay (l_stay),
      .left_val  (l_val),
      .left_prio (l_prio),
      .right_val (r_val),
      .right_prio(r_prio),
      .val       (cell_val[i]),
      .prio      (cell_prio[i]),
      .stay      (cell_stay[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    status_nxt = ST_INSERTED;
    if (in_ch.opcode == OP_INSERT) begin
      if (full) begin
        status_nxt = ST_DROP_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_POP_EMPTY;
      end else begin
        popped_nxt = cell_val[0];
        status_nxt = ST_POPPED;
        count_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.status       = status_r;
  assign out_ch.occupancy    = occ_r;

endmodule

[design/sspq_checker.sv]
module sspq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sspq_pkg::VALUE_W-1:0] out_popped_value,
  input sspq_pkg::status_t           out_status,
  input logic [sspq_pkg::OCC_W-1:0]  out_occupancy
);
  import sspq_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_popped_value) && $stable(out_occupancy))
    else $error("stalled result changed");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_POP_EMPTY |-> out_occupancy == '0 && out_popped_value == '0)
    else $error("pop on empty with nonzero occupancy or value");

  a_one_per_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

endmodule

bind stable_sorted_priority_queue sspq_checker u_sspq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_popped_value(out_ch.popped_value),
  .out_status      (out_ch.status),
  .out_occupancy   (out_ch.occupancy)
);
